// ===== hdl/polyphonic_wavetable_voice_mixer_assert.svh =====
// Assertion macros for the wavetable voice mixer.
`ifndef POLYPHONIC_WAVETABLE_VOICE_MIXER_ASSERT_SVH
`define POLYPHONIC_WAVETABLE_VOICE_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
`define PWVM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("pwvm assertion failed");
`define PWVM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("pwvm assertion failed");
`else
`define PWVM_ASSERT_IMP(label, clk, rst_n, a, c)
`define PWVM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== hdl/pwvm_pkg.sv =====
// Types and constants of the wavetable voice mixer.
package pwvm_pkg;
    localparam int CMD_W = 3;
    localparam int NOTE_W = 7;
    localparam int TIX_W = 12;
    localparam int SMP_W = 16;
    localparam int EV_W = 20;
    localparam int MIX_W = 27;
    localparam int POS_W = 21;
    localparam int STEP_W = 20;
    localparam int LVL_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int STEP_COUNT = 128;
    localparam logic [LVL_W-1:0] LEVEL_FULL = 8'hff;

    typedef enum logic [CMD_W-1:0] {
        CMD_NOTE_ON   = 3'd0,
        CMD_SAMPLE    = 3'd1,
        CMD_ENV_TICK  = 3'd2,
        CMD_WR_WAVE   = 3'd3,
        CMD_WR_STEP   = 3'd4,
        CMD_WR_ENV    = 3'd5,
        CMD_NOP6      = 3'd6,
        CMD_NOP7      = 3'd7
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVE_LEN = 2'd0,
        REG_LOOP_LEN = 2'd1,
        REG_ATTACK   = 2'd2,
        REG_ENV_LEN  = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VRD,
        ST_WRD1,
        ST_WRD2,
        ST_INTERP,
        ST_SCALE,
        ST_ACC,
        ST_ERD,
        ST_EWR,
        ST_NRD,
        ST_NWR,
        ST_OUT
    } state_t;
endpackage

// ===== hdl/polyphonic_wavetable_voice_mixer.sv =====
// Polyphonic wavetable voice mixer: top level with voice, wave, step and envelope memories.
// A note-on reads the step table, then writes a voice; a table write is done in idle; an
// envelope tick reads each voice in turn and may step its envelope; a sample tick works each
// sounding voice through VRD, WRD1, WRD2 (two sequential wave reads), INTERP, SCALE and ACC,
// each silent one through VRD and ACC, and ends in OUT. One item is worked at a time; a
// finished mix sits in an output register, and input is taken while it waits.
`include "polyphonic_wavetable_voice_mixer_assert.svh"
module polyphonic_wavetable_voice_mixer #(
    parameter int VOICES = 8,
    parameter int WAVE_DEPTH = 4096,
    parameter int ENVELOPE_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [pwvm_pkg::CMD_W-1:0] cmd,
    input  logic [pwvm_pkg::NOTE_W-1:0] note,
    input  logic [pwvm_pkg::TIX_W-1:0] table_index,
    input  logic signed [pwvm_pkg::SMP_W-1:0] wave_sample,
    input  logic [pwvm_pkg::EV_W-1:0] entry_value,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [pwvm_pkg::MIX_W-1:0] mix_out,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [pwvm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pwvm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pwvm_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int WW = $clog2(WAVE_DEPTH);
    localparam int EW = $clog2(ENVELOPE_DEPTH);
    localparam int VREC_W = STEP_W + POS_W + LVL_W + LVL_W;
    localparam int ELIM = (ENVELOPE_DEPTH < 256) ? ENVELOPE_DEPTH : 256;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [POS_W-1:0]  pos;
        logic [LVL_W-1:0]  level;
        logic [LVL_W-1:0]  eidx;
    } voice_t;

    // memories
    logic [VREC_W-1:0] voice_mem [VOICES];
    logic [VOICES-1:0] voice_vld_reg;
    logic [SMP_W-1:0]  wave_mem [WAVE_DEPTH];
    logic [STEP_W-1:0] step_mem [STEP_COUNT];
    logic [LVL_W-1:0]  env_mem [ENVELOPE_DEPTH];

    logic [11:0] wave_len_reg, loop_len_reg, attack_reg;
    logic [8:0]  env_len_reg;

    state_t state_reg, state_next;
    logic [VW-1:0] vcnt_reg, vcnt_next;
    logic [VW-1:0] next_voice_reg, next_voice_next;
    logic [NOTE_W-1:0] note_reg;
    voice_t vcur_reg, vcur_next;
    logic signed [SMP_W-1:0] s1_reg, s1_next;
    logic signed [SMP_W-1:0] smp_reg, smp_next;
    logic signed [MIX_W-1:0] prod_reg, prod_next;
    logic signed [MIX_W-1:0] acc_reg, acc_next;
    logic out_valid_reg, out_valid_next;
    logic signed [MIX_W-1:0] mix_reg, mix_next;

    // memory ports
    logic [VW-1:0]      v_raddr, v_waddr;
    logic               v_we;
    voice_t             v_wdata, v_rd_reg, v_rd;
    logic               v_rd_vld_reg;
    logic [WW-1:0]      w_raddr;
    logic [SMP_W-1:0]   w_rd_reg;
    logic [LVL_W-1:0]   e_rd_reg;
    logic [EW-1:0]      e_raddr;
    logic [STEP_W-1:0]  s_rd_reg;

    logic accept;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign mix_out = mix_reg;

    always_ff @(posedge clk)
    begin
        if (v_we)
            voice_mem[v_waddr] <= v_wdata;
        v_rd_reg <= voice_mem[v_raddr];
        w_rd_reg <= wave_mem[w_raddr];
        e_rd_reg <= env_mem[e_raddr];
        s_rd_reg <= step_mem[note_reg];
        if (accept && cmd == CMD_WR_WAVE && 32'(table_index) < WAVE_DEPTH)
            wave_mem[WW'(table_index)] <= wave_sample;
        if (accept && cmd == CMD_WR_STEP && 32'(table_index) < STEP_COUNT)
            step_mem[table_index[NOTE_W-1:0]] <= entry_value;
        if (accept && cmd == CMD_WR_ENV && 32'(table_index) < ENVELOPE_DEPTH)
            env_mem[EW'(table_index)] <= entry_value[LVL_W-1:0];
    end

    // voice memory has a reset value: valid bits per entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_vld_reg <= '0;
            v_rd_vld_reg <= 1'b0;
        end
        else
        begin
            v_rd_vld_reg <= voice_vld_reg[v_raddr];
            if (v_we)
                voice_vld_reg[v_waddr] <= 1'b1;
        end
    end
    assign v_rd = v_rd_vld_reg ? v_rd_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_len_reg <= 12'd4095;
            loop_len_reg <= 12'd2048;
            attack_reg <= 12'd2048;
            env_len_reg <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_WAVE_LEN: wave_len_reg <= cfg_data;
                REG_LOOP_LEN: loop_len_reg <= cfg_data;
                REG_ATTACK:   attack_reg <= cfg_data;
                REG_ENV_LEN:  env_len_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vcnt_reg <= '0;
            next_voice_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vcnt_reg <= vcnt_next;
            next_voice_reg <= next_voice_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            note_reg <= note;
        vcur_reg <= vcur_next;
        s1_reg <= s1_next;
        smp_reg <= smp_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        mix_reg <= mix_next;
    end

    logic [POS_W:0] pos_sum;
    logic [POS_W:0] pos_new;
    logic signed [SMP_W:0] dif;
    logic signed [SMP_W+9:0] dmul;
    logic [8:0] eidx_inc;
    logic last_voice;

    always_comb
    begin
        state_next = state_reg;
        vcnt_next = vcnt_reg;
        next_voice_next = next_voice_reg;
        vcur_next = vcur_reg;
        s1_next = s1_reg;
        smp_next = smp_reg;
        prod_next = prod_reg;
        acc_next = acc_reg;
        mix_next = mix_reg;
        out_valid_next = out_valid_reg && out_stall;
        v_raddr = vcnt_reg;
        v_waddr = vcnt_reg;
        v_we = 1'b0;
        v_wdata = vcur_reg;
        w_raddr = WW'(vcur_reg.pos[POS_W-1:8]);
        e_raddr = EW'(vcur_reg.eidx);
        last_voice = (32'(vcnt_reg) == VOICES - 1);
        pos_sum = {1'b0, vcur_reg.pos} + (POS_W+1)'(vcur_reg.step);
        pos_new = pos_sum;
        if (pos_sum >= {2'b0, wave_len_reg, 8'h00})
            pos_new = pos_sum - {2'b0, loop_len_reg, 8'h00};
        dif = (SMP_W+1)'(signed'(w_rd_reg)) - (SMP_W+1)'(s1_reg);
        dmul = (SMP_W+10)'(dif) * $signed({2'b0, vcur_reg.pos[7:0]});
        eidx_inc = {1'b0, vcur_reg.eidx} + 9'd1;

        case (state_reg)
            ST_IDLE:
            begin
                vcnt_next = '0;
                acc_next = '0;
                if (accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_NOTE_ON:  state_next = ST_NRD;
                        CMD_SAMPLE:   state_next = ST_VRD;
                        CMD_ENV_TICK: state_next = ST_ERD;
                        default: ;
                    endcase
                    v_raddr = '0;
                end
            end
            ST_NRD:
                state_next = ST_NWR;
            ST_NWR:
            begin
                v_we = 1'b1;
                v_waddr = next_voice_reg;
                v_wdata = '{step: s_rd_reg, pos: '0, level: LEVEL_FULL, eidx: '0};
                next_voice_next = (32'(next_voice_reg) == VOICES - 1) ? '0
                                : next_voice_reg + VW'(1);
                state_next = ST_IDLE;
            end
            ST_VRD:
            begin
                vcur_next = v_rd;
                state_next = (v_rd.level != '0) ? ST_WRD1 : ST_ACC;
            end
            ST_WRD1:
            begin
                w_raddr = WW'(vcur_reg.pos[POS_W-1:8]);
                state_next = ST_WRD2;
            end
            ST_WRD2:
            begin
                w_raddr = WW'({1'b0, vcur_reg.pos[POS_W-1:8]} + 14'd1);
                s1_next = signed'(w_rd_reg);
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                smp_next = s1_reg + SMP_W'(dmul >>> 8);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                prod_next = MIX_W'($signed({1'b0, vcur_reg.level})) * MIX_W'(smp_reg);
                v_we = 1'b1;
                v_wdata.pos = pos_new[POS_W-1:0];
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (vcur_reg.level != '0)
                    acc_next = acc_reg + prod_reg;
                vcnt_next = vcnt_reg + VW'(1);
                v_raddr = vcnt_reg + VW'(1);
                if (last_voice)
                    state_next = ST_OUT;
                else
                    state_next = ST_VRD;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    mix_next = acc_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ERD:
            begin
                vcur_next = v_rd;
                e_raddr = EW'(v_rd.eidx);
                state_next = ST_EWR;
            end
            ST_EWR:
            begin
                if (vcur_reg.pos[POS_W-1:8] >= {1'b0, attack_reg}
                    && 32'(eidx_inc) < 32'(env_len_reg) && 32'(eidx_inc) < ELIM)
                begin
                    v_we = 1'b1;
                    v_wdata.level = e_rd_reg;
                    v_wdata.eidx = eidx_inc[LVL_W-1:0];
                end
                vcnt_next = vcnt_reg + VW'(1);
                v_raddr = vcnt_reg + VW'(1);
                state_next = last_voice ? ST_IDLE : ST_ERD;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    `PWVM_ASSERT_IMP(a_out_hold, clk, rst_n, out_valid && out_stall && state_reg == ST_OUT, state_next == ST_OUT)
    `PWVM_ASSERT_IMP(a_idle_ready, clk, rst_n, state_reg == ST_IDLE, !in_stall && cfg_ready)
    `PWVM_ASSERT_NXT(a_note_two, clk, rst_n, accept && cmd == CMD_NOTE_ON, state_reg == ST_NRD)
    `PWVM_ASSERT_NXT(a_out_from_tick, clk, rst_n, !out_valid && state_reg != ST_OUT, !out_valid)
endmodule
